// ===== rtl/core/mmw_pkg.sv =====
// Shared constants and types of the 4x4 matrix multiplier with wide accumulator.
package mmw_pkg;

  localparam int DIM_DEF    = 4;
  localparam int ELEM_W     = 32;
  localparam int IDX_OUT_W  = 2;
  localparam int SUM_LOW_W  = 64;
  localparam int SUM_HIGH_W = 2;
  localparam int ACC_W      = SUM_LOW_W + SUM_HIGH_W;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int RES_DEPTH  = 4;

  // Control carried alongside one multiply-accumulate step
  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 lastk;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] column;
    logic                 last_of_run;
  } tag_t;

  // One finished result element
  typedef struct packed {
    logic [IDX_OUT_W-1:0]  row;
    logic [IDX_OUT_W-1:0]  column;
    logic [SUM_LOW_W-1:0]  sum_low;
    logic [SUM_HIGH_W-1:0] sum_high;
    logic                  last_of_run;
  } res_t;

endpackage

// ===== rtl/core/mmw_in_if.sv =====
// Input channel: one matrix word per transaction.
interface mmw_in_if;
  logic                       valid;
  logic                       ready;
  logic [mmw_pkg::ELEM_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

// ===== rtl/core/mmw_out_if.sv =====
// Result channel: one element of C per transaction.
interface mmw_out_if;
  logic                           valid;
  logic                           ready;
  logic [mmw_pkg::IDX_OUT_W-1:0]  row;
  logic [mmw_pkg::IDX_OUT_W-1:0]  column;
  logic [mmw_pkg::SUM_LOW_W-1:0]  sum_low;
  logic [mmw_pkg::SUM_HIGH_W-1:0] sum_high;
  logic                           last_of_run;

  modport source (output valid, output row, output column, output sum_low,
                  output sum_high, output last_of_run, input ready);
  modport sink   (input valid, input row, input column, input sum_low,
                  input sum_high, input last_of_run, output ready);
endinterface

// ===== rtl/core/mmw_store.sv =====
// Matrix store: separate A and B memories, one write port, registered reads.
module mmw_store #(
  parameter int DIM = mmw_pkg::DIM_DEF
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic                              wr_b,
  input  logic [$clog2(DIM*DIM)-1:0]        wr_addr,
  input  logic [mmw_pkg::ELEM_W-1:0]        wr_data,
  input  logic [$clog2(DIM*DIM)-1:0]        rd_a_addr,
  input  logic [$clog2(DIM*DIM)-1:0]        rd_b_addr,
  output logic [mmw_pkg::ELEM_W-1:0]        a_rdata_r,
  output logic [mmw_pkg::ELEM_W-1:0]        b_rdata_r
);

  localparam int CELLS = DIM * DIM;

  logic [mmw_pkg::ELEM_W-1:0] a_mem [CELLS];
  logic [mmw_pkg::ELEM_W-1:0] b_mem [CELLS];

  // Write the incoming word into A or B
  always_ff @(posedge clk) begin
    if (wr_en && !wr_b) begin
      a_mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_b) begin
      b_mem[wr_addr] <= wr_data;
    end
  end

  // Read both operands every cycle
  always_ff @(posedge clk) begin
    a_rdata_r <= a_mem[rd_a_addr];
    b_rdata_r <= b_mem[rd_b_addr];
  end

endmodule

// ===== rtl/core/mmw_mac.sv =====
// Shared multiply-accumulate unit: registered 32x32 product, then 66-bit accumulate.
module mmw_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mmw_pkg::ELEM_W-1:0] a_data,
  input  logic [mmw_pkg::ELEM_W-1:0] b_data,
  input  mmw_pkg::tag_t              tag_in,
  output logic                       res_valid,
  output mmw_pkg::res_t              res
);

  logic [mmw_pkg::PROD_W-1:0] prod_r;
  mmw_pkg::tag_t              ptag_r;
  logic [mmw_pkg::ACC_W-1:0]  acc_r;
  logic [mmw_pkg::ACC_W-1:0]  acc_nxt;

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r <= a_data * b_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptag_r <= '0;
    end else begin
      ptag_r <= tag_in;
    end
  end

  // Accumulate, restarting on the first term of each element; wraps modulo 2^66
  always_comb begin
    acc_nxt = (ptag_r.first ? '0 : acc_r) + mmw_pkg::ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (ptag_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // Hand the element on with its last term
  always_comb begin
    res_valid       = ptag_r.valid && ptag_r.lastk;
    res.row         = ptag_r.row;
    res.column      = ptag_r.column;
    res.sum_low     = acc_nxt[mmw_pkg::SUM_LOW_W-1:0];
    res.sum_high    = acc_nxt[mmw_pkg::ACC_W-1:mmw_pkg::SUM_LOW_W];
    res.last_of_run = ptag_r.last_of_run;
  end

endmodule

// ===== rtl/core/mmw_resq.sv =====
// Result queue: a few elements of C held for the receiver, driving the result channel.
module mmw_resq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mmw_pkg::res_t    push_data,
  output logic             pop,
  mmw_out_if.source        out_chan
);

  localparam int PW  = $clog2(mmw_pkg::RES_DEPTH);
  localparam int CNW = $clog2(mmw_pkg::RES_DEPTH + 1);

  mmw_pkg::res_t  q_mem [mmw_pkg::RES_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  mmw_pkg::res_t  head;
  logic           full;

  // Present the head entry
  always_comb begin
    head                 = q_mem[rp_r];
    out_chan.valid       = cnt_r != '0;
    out_chan.row         = head.row;
    out_chan.column      = head.column;
    out_chan.sum_low     = head.sum_low;
    out_chan.sum_high    = head.sum_high;
    out_chan.last_of_run = head.last_of_run;
    pop                  = out_chan.valid && out_chan.ready;
    full                 = cnt_r == CNW'(mmw_pkg::RES_DEPTH);
  end

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(mmw_pkg::RES_DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(mmw_pkg::RES_DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNW'(1);
      2'b01:   cnt_nxt = cnt_r - CNW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("result queue written while full");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - CNW'(1))
    else $error("result queue count did not drop on pop");
`endif

endmodule

// ===== rtl/core/matmul_4x4_u32_wide_acc.sv =====
// Top level of the streaming matrix multiplier: load sequencer, step issue and credits.
//
// Usage: send 2*DIM*DIM unsigned 32-bit words on in_chan, matrix A row-major then
// matrix B row-major, one word per transaction. After the last word of B the block
// returns the DIM*DIM elements of C = A * B on out_chan in row-major order, each as
// a 64-bit low part and the two bits above it, with last_of_run set on the final one.
// In_chan is ready throughout loading and held not ready while the products are
// issued: DIM*DIM*DIM multiply-accumulate steps through the single 32x32 multiplier,
// one step a cycle while the result queue has credit for each new element. Each
// result passes the store read register, the product register and the result queue
// before out_chan offers it. Loading of the next run may start as soon as the
// last step is issued. A four-entry result queue parts the unit from the receiver;
// when out_chan stalls, issue of a new element waits for queue credit and resumes
// without loss. Reset (rst_n low, synchronous) empties the queue and pipeline and
// starts a fresh run; the matrix store is not cleared, every word is written first.
module matmul_4x4_u32_wide_acc #(
  parameter int DIM = mmw_pkg::DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mmw_in_if.sink     in_chan,
  mmw_out_if.source  out_chan
);

  localparam int CELLS = DIM * DIM;
  localparam int WORDS = 2 * CELLS;
  localparam int CW    = $clog2(CELLS);
  localparam int LW    = $clog2(WORDS);
  localparam int IW    = $clog2(DIM);
  localparam int CRW   = $clog2(mmw_pkg::RES_DEPTH + 1);
  localparam logic [CW-1:0] DIM_C = CW'(DIM);

  typedef enum logic {S_LOAD, S_CALC} state_t;

  state_t         state_r, state_nxt;
  logic [LW-1:0]  cnt_r, cnt_nxt;
  logic [IW-1:0]  r_r, r_nxt;
  logic [IW-1:0]  c_r, c_nxt;
  logic [IW-1:0]  k_r, k_nxt;
  logic [CRW-1:0] credit_r, credit_nxt;
  mmw_pkg::tag_t  tag_r, tag_nxt;

  logic                       in_acc;
  logic                       in_last;
  logic                       wr_b;
  logic [CW-1:0]              wr_addr;
  logic                       issue;
  logic                       take_credit;
  logic                       k_end, c_end, r_end;
  logic [CW-1:0]              rd_a_addr, rd_b_addr;
  logic [IW+1:0]              row_ext, col_ext;
  logic [mmw_pkg::ELEM_W-1:0] a_rdata, b_rdata;
  logic                       res_valid;
  mmw_pkg::res_t              res;
  logic                       pop;

  // Load side
  always_comb begin
    in_chan.ready = state_r == S_LOAD;
    in_acc        = in_chan.valid && in_chan.ready;
    in_last       = cnt_r == LW'(WORDS - 1);
    wr_b          = cnt_r >= LW'(CELLS);
    wr_addr       = wr_b ? CW'(cnt_r - LW'(CELLS)) : CW'(cnt_r);
  end

  // Issue one step a cycle; a new element needs a free slot in the result queue
  always_comb begin
    issue       = (state_r == S_CALC) &&
                  ((k_r != '0) || (credit_r < CRW'(mmw_pkg::RES_DEPTH)));
    take_credit = issue && (k_r == '0);
    k_end       = k_r == IW'(DIM - 1);
    c_end       = c_r == IW'(DIM - 1);
    r_end       = r_r == IW'(DIM - 1);
    rd_a_addr   = CW'(CW'(r_r) * DIM_C) + CW'(k_r);
    rd_b_addr   = CW'(CW'(k_r) * DIM_C) + CW'(c_r);
    row_ext     = {2'b00, r_r};
    col_ext     = {2'b00, c_r};

    tag_nxt.valid       = issue;
    tag_nxt.first       = k_r == '0;
    tag_nxt.lastk       = k_end;
    tag_nxt.row         = row_ext[mmw_pkg::IDX_OUT_W-1:0];
    tag_nxt.column      = col_ext[mmw_pkg::IDX_OUT_W-1:0];
    tag_nxt.last_of_run = r_end && c_end;
  end

  // Next state, counters and credits
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (in_last) begin
            cnt_nxt   = '0;
            r_nxt     = '0;
            c_nxt     = '0;
            k_nxt     = '0;
            state_nxt = S_CALC;
          end else begin
            cnt_nxt = cnt_r + LW'(1);
          end
        end
      end
      S_CALC: begin
        if (issue) begin
          if (!k_end) begin
            k_nxt = k_r + IW'(1);
          end else begin
            k_nxt = '0;
            if (!c_end) begin
              c_nxt = c_r + IW'(1);
            end else begin
              c_nxt = '0;
              if (!r_end) begin
                r_nxt = r_r + IW'(1);
              end else begin
                r_nxt     = '0;
                state_nxt = S_LOAD;
              end
            end
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase

    case ({take_credit, pop})
      2'b10:   credit_nxt = credit_r + CRW'(1);
      2'b01:   credit_nxt = credit_r - CRW'(1);
      default: credit_nxt = credit_r;
    endcase
  end

  // Hold state, counters and the step tag aligned with the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      cnt_r    <= '0;
      r_r      <= '0;
      c_r      <= '0;
      k_r      <= '0;
      credit_r <= '0;
      tag_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      r_r      <= r_nxt;
      c_r      <= c_nxt;
      k_r      <= k_nxt;
      credit_r <= credit_nxt;
      tag_r    <= tag_nxt;
    end
  end

  mmw_store #(.DIM(DIM)) u_store (
    .clk       (clk),
    .wr_en     (in_acc),
    .wr_b      (wr_b),
    .wr_addr   (wr_addr),
    .wr_data   (in_chan.element),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .a_rdata_r (a_rdata),
    .b_rdata_r (b_rdata)
  );

  mmw_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .tag_in    (tag_r),
    .res_valid (res_valid),
    .res       (res)
  );

  mmw_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (pop),
    .out_chan  (out_chan)
  );

`ifndef ASSERT_OFF
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRW'(mmw_pkg::RES_DEPTH))
    else $error("result credits exceed queue depth");

  a_pop_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> credit_r != '0)
    else $error("result delivered without an outstanding element");

  a_run_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (state_r == S_CALC && r_r == '0 && c_r == '0 && k_r == '0))
    else $error("last word of B did not start the product pass");
`endif

endmodule

// ===== tb/sv/mmw_result_checker.sv =====
// Checker for the matrix multiplier: mirrors the loaded words and checks every element of C.
module mmw_result_checker (
  input  logic clk,
  input  logic rst_n,
  mmw_in_if    in_mon,
  mmw_out_if   out_mon,
  output int   fail_count,
  output int   elems_due
);

  localparam int DIM   = mmw_pkg::DIM_DEF;
  localparam int CELLS = DIM * DIM;
  localparam int WORDS = 2 * CELLS;

  logic [mmw_pkg::ELEM_W-1:0] word_store [WORDS];
  int unsigned                words_loaded;
  mmw_pkg::res_t              c_elements_due[$];

  initial begin
    fail_count   = 0;
    elems_due    = 0;
    words_loaded = 0;
  end

  // Store one word of A or B; on the last word of B queue the whole of C
  task automatic take_matrix_word(input logic [mmw_pkg::ELEM_W-1:0] word);
    logic [mmw_pkg::ACC_W-1:0] dot;
    mmw_pkg::res_t             elem;
    word_store[words_loaded] = word;
    words_loaded++;
    if (words_loaded == WORDS) begin
      words_loaded = 0;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          dot = '0;
          for (int k = 0; k < DIM; k++) begin
            dot = dot + mmw_pkg::ACC_W'(word_store[r * DIM + k]) *
                        mmw_pkg::ACC_W'(word_store[CELLS + k * DIM + c]);
          end
          elem.row         = mmw_pkg::IDX_OUT_W'(r);
          elem.column      = mmw_pkg::IDX_OUT_W'(c);
          elem.sum_low     = dot[mmw_pkg::SUM_LOW_W-1:0];
          elem.sum_high    = dot[mmw_pkg::ACC_W-1:mmw_pkg::SUM_LOW_W];
          elem.last_of_run = (r == DIM - 1) && (c == DIM - 1);
          c_elements_due.push_back(elem);
        end
      end
    end
  endtask

  // Compare one returned element with the oldest one due
  task automatic check_element();
    mmw_pkg::res_t due;
    if (c_elements_due.size() == 0) begin
      $error("result with nothing due: row %0d column %0d sum_low %h sum_high %0d",
             out_mon.row, out_mon.column, out_mon.sum_low, out_mon.sum_high);
      fail_count++;
    end else begin
      due = c_elements_due.pop_front();
      if (out_mon.row !== due.row) begin
        $error("row: expected %0d, got %0d", due.row, out_mon.row);
        fail_count++;
      end
      if (out_mon.column !== due.column) begin
        $error("column: expected %0d, got %0d", due.column, out_mon.column);
        fail_count++;
      end
      if (out_mon.sum_low !== due.sum_low) begin
        $error("sum_low: expected %h, got %h", due.sum_low, out_mon.sum_low);
        fail_count++;
      end
      if (out_mon.sum_high !== due.sum_high) begin
        $error("sum_high: expected %0d, got %0d", due.sum_high, out_mon.sum_high);
        fail_count++;
      end
      if (out_mon.last_of_run !== due.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", due.last_of_run, out_mon.last_of_run);
        fail_count++;
      end
    end
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) check_element();
      if (in_mon.valid && in_mon.ready) take_matrix_word(in_mon.element);
    end
    elems_due = c_elements_due.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the matrix multiplier testbench: clock, reset, word stream, result sink and verdict.
module tb_top;

  localparam int DIM            = mmw_pkg::DIM_DEF;
  localparam int EW             = mmw_pkg::ELEM_W;
  localparam int WORDS_PER_RUN  = 2 * DIM * DIM;
  localparam int DIRECTED_RUNS  = 2;
  localparam int RANDOM_RUNS    = 7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF       = 400;
  localparam int DRAIN_CYCLES   = 32;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   elems_due;
  int   results_seen;
  bit   sender_quiet;

  mmw_in_if  in_chan();
  mmw_out_if out_chan();

  matmul_4x4_u32_wide_acc DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  mmw_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .elems_due  (elems_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Count returned elements for the sink's pacing
  initial results_seen = 0;
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) results_seen++;
  end

  // Word with a random shape: full range, extremes, small, single bit, near the top
  function automatic logic [EW-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom;
    if (pick < 60) return '1;
    if (pick < 68) return '0;
    if (pick < 78) return EW'($urandom_range(255));
    if (pick < 88) return EW'(1) << $urandom_range(EW - 1);
    return '1 - EW'($urandom_range(255));
  endfunction

  // Directed content: all-ones run to reach the top carry bits, then an identity A
  function automatic logic [EW-1:0] directed_word(input int run, input int idx);
    int pos;
    if (run == 0) return '1;
    if (idx < DIM * DIM) return (idx % (DIM + 1) == 0) ? EW'(1) : '0;
    pos = idx - DIM * DIM;
    case (pos % 4)
      0:       return '1;
      1:       return '0;
      2:       return 32'h8000_0001;
      default: return EW'(1) << (pos * 2);
    endcase
  endfunction

  // Offer one word, idling now and then, and hold it until taken
  task automatic send_word(input logic [EW-1:0] word);
    while (!sender_quiet && $urandom_range(99) < 8) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid   = 1'b1;
    in_chan.element = word;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Result sink: random stalls, one long hold-off, and a quiet stretch
  initial begin : result_sink
    bit held_off;
    held_off       = 1'b0;
    out_chan.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 40) begin
        held_off       = 1'b1;
        out_chan.ready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      if (results_seen >= 112 && results_seen < 176) out_chan.ready = 1'b1;
      else out_chan.ready = ($urandom_range(99) >= 8);
    end
  end

  // Abort when nothing moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("matmul_4x4_u32_wide_acc: mismatch");
    $finish;
  end

  // Stimulus and verdict
  initial begin : word_stream
    rst_n           = 1'b0;
    sender_quiet    = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.element = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (int run = 0; run < DIRECTED_RUNS; run++) begin
      for (int i = 0; i < WORDS_PER_RUN; i++) send_word(directed_word(run, i));
    end

    for (int run = 0; run < RANDOM_RUNS; run++) begin
      sender_quiet = (run >= 3 && run < 6);
      for (int i = 0; i < WORDS_PER_RUN; i++) send_word(random_word());
    end
    in_chan.valid = 1'b0;

    // Drain the outstanding elements, then watch for strays
    while (elems_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("matmul_4x4_u32_wide_acc: match");
    end else begin
      $display("matmul_4x4_u32_wide_acc: mismatch");
    end
    $finish;
  end

endmodule

// ===== matmul_4x4_u32_wide_acc.f =====
rtl/core/mmw_pkg.sv
rtl/core/mmw_in_if.sv
rtl/core/mmw_out_if.sv
rtl/core/mmw_store.sv
rtl/core/mmw_mac.sv
rtl/core/mmw_resq.sv
rtl/core/matmul_4x4_u32_wide_acc.sv
tb/sv/mmw_result_checker.sv
tb/sv/tb_top.sv
